[rtl/core/lzw_pkg.sv]
package lzw_pkg;

    localparam int WINDOW_SIZE = 4096;
    localparam int MAX_MATCH   = 18;
    localparam int MIN_LEN     = 3;
    localparam int GROUP_TOK   = 8;
    localparam int GROUP_BYTES = 16;
    localparam int FIFO_DEPTH  = 4;

    localparam int AW  = $clog2(WINDOW_SIZE);
    localparam int LW  = $clog2(MAX_MATCH + 1);
    localparam int GBW = $clog2(GROUP_BYTES + 1);
    localparam int FPW = $clog2(FIFO_DEPTH);

    localparam logic [7:0]    FILL_BYTE  = 8'h20;
    localparam logic [AW-1:0] POS_OFFSET = AW'(16);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_LOAD,
        S_START,
        S_SEARCH,
        S_DECIDE,
        S_COMMIT,
        S_FLUSH
    } t_state;

endpackage

[rtl/core/lzw_fifo.sv]
module lzw_fifo
    import lzw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    t_item          r_mem [FIFO_DEPTH];
    logic [FPW-1:0] r_wr;
    logic [FPW-1:0] r_rd;
    logic [FPW:0]   r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == (FPW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[rtl/core/lzw_engine.sv]
module lzw_engine
    import lzw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_empty,
    input  t_item i_in_item,
    output logic  o_in_pop,
    input  logic  i_out_full,
    output logic  o_out_push,
    output t_item o_out_item
);

    t_state          r_state;
    t_state          n_state;

    logic [7:0]      r_win [WINDOW_SIZE];
    logic [7:0]      r_rdata;
    logic [AW-1:0]   r_clr;

    logic [7:0]      r_la [MAX_MATCH];
    logic [LW-1:0]   r_cnt;
    logic [AW-1:0]   r_wp;
    logic            r_end;

    logic [AW-1:0]   r_addr;
    logic            r_pv;
    logic [AW-1:0]   r_pp;
    logic [MAX_MATCH:0] r_act;
    logic [LW-1:0]   r_best;
    logic [AW-1:0]   r_bpos;
    logic [LW-1:0]   r_take;

    logic [7:0]      r_flag;
    logic [7:0]      r_grp [GROUP_BYTES];
    logic [3:0]      r_tok;
    logic [GBW-1:0]  r_gb;
    logic [GBW-1:0]  r_fidx;
    logic            r_final;

    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [7:0]      mem_wd;

    logic            issue_done;
    logic            alive;
    logic            hit_full;
    logic            fin_v;
    logic [LW-1:0]   fin_len;
    logic [LW-1:0]   fin_lane;
    logic [AW-1:0]   fin_cand;
    logic [AW-1:0]   cur_pos;
    logic [MAX_MATCH:0] n_act;
    logic            best_upd;

    logic            commit_last;
    logic            done_all;
    logic            need_flush;
    logic            flush_end;
    logic [11:0]     mpos;
    logic [LW-1:0]   mlen;

    // window memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_win[mem_wa] <= mem_wd;
        end
        r_rdata <= r_win[r_addr];
    end

    assign issue_done  = (r_addr == r_wp);
    assign commit_last = (r_take == LW'(1));
    assign done_all    = r_end && (r_cnt == LW'(1));
    assign need_flush  = (r_tok == 4'(GROUP_TOK)) || (done_all && r_tok != '0);
    assign flush_end   = !i_out_full && (r_fidx == r_gb);
    assign mpos        = 12'(r_bpos - POS_OFFSET);
    assign mlen        = r_best - LW'(MIN_LEN);

    // candidate lanes: lane j holds the candidate that has matched j bytes
    always_comb begin
        fin_v    = 1'b0;
        fin_len  = '0;
        hit_full = 1'b0;
        n_act    = '0;
        alive    = 1'b0;
        cur_pos  = r_pv ? r_pp : r_wp;
        if (r_pv) begin
            for (int j = 0; j < MAX_MATCH; j++) begin
                if (j < int'(r_cnt)) begin
                    alive = (j == 0) ? 1'b1 : r_act[j];
                    if (alive && r_rdata == r_la[j]) begin
                        if ((j + 1) == int'(r_cnt)) begin
                            hit_full = 1'b1;
                        end else begin
                            n_act[j+1] = 1'b1;
                        end
                    end else if (alive) begin
                        fin_v   = 1'b1;
                        fin_len = LW'(j);
                    end
                end
            end
            if (hit_full) begin
                fin_v   = 1'b1;
                fin_len = r_cnt;
            end
        end else begin
            for (int j = 1; j < MAX_MATCH; j++) begin
                if (r_act[j]) begin
                    fin_v   = 1'b1;
                    fin_len = LW'(j);
                end
            end
        end
        fin_lane = hit_full ? (r_cnt - 1'b1) : fin_len;
        fin_cand = cur_pos - AW'(fin_lane);
        best_upd = fin_v && (fin_len >= LW'(MIN_LEN)) && (fin_len > r_best);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!i_in_empty &&
                    (i_in_item.last || r_cnt == LW'(MAX_MATCH - 1))) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_SEARCH;
            end
            S_SEARCH: begin
                if ((r_pv && hit_full) || (!r_pv && issue_done)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (commit_last) begin
                    priority if (need_flush) begin
                        n_state = S_FLUSH;
                    end else if (done_all) begin
                        n_state = S_CLEAR;
                    end else if (r_end) begin
                        n_state = S_START;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_FLUSH: begin
                if (flush_end) begin
                    priority if (r_final) begin
                        n_state = S_CLEAR;
                    end else if (r_end) begin
                        n_state = S_START;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_in_pop        = (r_state == S_LOAD) && !i_in_empty;
        o_out_push      = (r_state == S_FLUSH) && !i_out_full;
        o_out_item.data = (r_fidx == '0) ? r_flag : r_grp[4'(r_fidx - 1'b1)];
        o_out_item.last = r_final && (r_fidx == r_gb);
        mem_we          = 1'b0;
        mem_wa          = r_wp;
        mem_wd          = r_la[0];
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = FILL_BYTE;
            end
            S_COMMIT: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_wp    <= '0;
            r_end   <= 1'b0;
            r_pv    <= 1'b0;
            r_tok   <= '0;
            r_gb    <= '0;
            r_flag  <= '0;
            r_fidx  <= '0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr   <= r_clr + 1'b1;
                    r_cnt   <= '0;
                    r_wp    <= '0;
                    r_end   <= 1'b0;
                    r_tok   <= '0;
                    r_gb    <= '0;
                    r_flag  <= '0;
                    r_final <= 1'b0;
                end
                S_LOAD: begin
                    if (!i_in_empty) begin
                        r_la[r_cnt] <= i_in_item.data;
                        r_cnt       <= r_cnt + 1'b1;
                        if (i_in_item.last) begin
                            r_end <= 1'b1;
                        end
                    end
                end
                S_START: begin
                    r_addr <= r_wp + 1'b1;
                    r_pv   <= 1'b0;
                    r_act  <= '0;
                    r_best <= '0;
                end
                S_SEARCH: begin
                    if (!issue_done) begin
                        r_addr <= r_addr + 1'b1;
                        r_pp   <= r_addr;
                        r_pv   <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        r_act <= n_act;
                    end
                    if (best_upd) begin
                        r_best <= fin_len;
                        r_bpos <= fin_cand;
                    end
                end
                S_DECIDE: begin
                    r_pv  <= 1'b0;
                    r_tok <= r_tok + 1'b1;
                    if (r_best != '0) begin
                        r_grp[4'(r_gb)]        <= mpos[7:0];
                        r_grp[4'(r_gb + 1'b1)] <= {mpos[11:8], mlen[3:0]};
                        r_gb                   <= r_gb + GBW'(2);
                        r_take                 <= r_best;
                    end else begin
                        r_flag[r_tok[2:0]] <= 1'b1;
                        r_grp[4'(r_gb)]    <= r_la[0];
                        r_gb               <= r_gb + 1'b1;
                        r_take             <= LW'(1);
                    end
                end
                S_COMMIT: begin
                    r_wp   <= r_wp + 1'b1;
                    r_cnt  <= r_cnt - 1'b1;
                    r_take <= r_take - 1'b1;
                    for (int j = 0; j < MAX_MATCH - 1; j++) begin
                        r_la[j] <= r_la[j+1];
                    end
                    r_final <= done_all;
                    r_fidx  <= '0;
                end
                S_FLUSH: begin
                    if (!i_out_full) begin
                        r_fidx <= r_fidx + 1'b1;
                        if (r_fidx == r_gb) begin
                            r_tok  <= '0;
                            r_gb   <= '0;
                            r_flag <= '0;
                        end
                    end
                end
                default: begin
                    r_pv <= 1'b0;
                end
            endcase
        end
    end

endmodule

[rtl/core/lzss_window_compressor.sv]
// LZSS compressor, 4096-byte window of spaces, 18-byte lookahead.
// Input queue: drive i_in_byte/i_in_last and raise i_push while o_full is
// low; a request is taken at each such edge. i_in_last marks stream end.
// Output queue: while o_empty is low, o_out_byte/o_out_last hold the oldest
// compressed byte; raise i_pop to take it. o_out_last marks the final byte.
// A four-entry queue sits on each side, so the source and the sink can
// stall independently of the search engine.
// Each token takes one window-memory read per candidate position, then
// one window write per byte consumed; a token is chosen whenever 18 bytes
// are buffered or the stream has ended (roughly one per input byte on
// incompressible data). Group output sends a flag byte plus up to 16
// payload bytes, one per cycle while the output queue has room.
// Reset (i_rst_n low, synchronous) empties both queues and starts a
// pass that fills the window with spaces; input requests queue up but
// none is processed until it ends. The same pass runs after the last
// byte of every stream, so each stream starts fresh.
module lzss_window_compressor
    import lzw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    t_item in_item;
    t_item eng_in;
    t_item eng_out;
    t_item out_item;
    logic  in_empty;
    logic  in_pop;
    logic  out_full;
    logic  out_push;

    assign in_item.data = i_in_byte;
    assign in_item.last = i_in_last;
    assign o_out_byte   = out_item.data;
    assign o_out_last   = out_item.last;

    lzw_fifo u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (in_item),
        .o_full  (o_full),
        .i_pop   (in_pop),
        .o_item  (eng_in),
        .o_empty (in_empty)
    );

    lzw_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_empty (in_empty),
        .i_in_item  (eng_in),
        .o_in_pop   (in_pop),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_out_item (eng_out)
    );

    lzw_fifo u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_item  (eng_out),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_item  (out_item),
        .o_empty (o_empty)
    );

endmodule
